// ===== rtl/eop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_pkg
// Shared types, codes and lookup functions of the EXIF orientation parser.
// ----------------------------------------------------------------------------
package eop_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [15:0] ORIENT_TAG  = 16'h0112;
    localparam logic [15:0] TYPE_SHORT  = 16'd3;
    localparam logic [31:0] COUNT_ONE   = 32'd1;
    localparam logic [32:0] IFD_BASE    = 33'd12;
    localparam logic [32:0] IFD_MIN     = 33'd20;

    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] TIFF_MAGIC = 8'h2A;

    typedef logic [7:0] data_t;
    typedef logic [2:0] code_t;
    typedef logic [2:0] status_t;

    localparam status_t ST_FOUND       = 3'd0;
    localparam status_t ST_BAD_MARKER  = 3'd1;
    localparam status_t ST_BAD_EXIF    = 3'd2;
    localparam status_t ST_BAD_TIFF    = 3'd3;
    localparam status_t ST_TAG_MISSING = 3'd4;
    localparam status_t ST_BAD_VALUE   = 3'd5;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_COUNT  = 5'b00100,
        PH_ENTRY  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    // SOI followed by the APP1 marker
    function automatic data_t marker_byte(input logic [1:0] idx);
        data_t b;
        begin
            case (idx)
                2'd0:    b = 8'hFF;
                2'd1:    b = 8'hD8;
                2'd2:    b = 8'hFF;
                default: b = 8'hE1;
            endcase
            return b;
        end
    endfunction

    // "Exif" and two zero bytes
    function automatic data_t exif_byte(input logic [2:0] idx);
        data_t b;
        begin
            case (idx)
                3'd0:    b = 8'h45;
                3'd1:    b = 8'h78;
                3'd2:    b = 8'h69;
                3'd3:    b = 8'h66;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // orientation value 1..8 to code; idx is value minus one
    function automatic code_t orient_code(input logic [2:0] idx);
        code_t c;
        begin
            case (idx)
                3'd0:    c = 3'd0;
                3'd1:    c = 3'd1;
                3'd2:    c = 3'd3;
                3'd3:    c = 3'd2;
                3'd4:    c = 3'd7;
                3'd5:    c = 3'd4;
                3'd6:    c = 3'd6;
                default: c = 3'd5;
            endcase
            return c;
        end
    endfunction

    // Add byte k of a multi-byte field in the current byte order
    function automatic logic [31:0] gather(input logic [31:0] word, input data_t b,
                                           input logic [1:0] k, input logic le);
        logic [31:0] base;
        begin
            base = (k == 2'd0) ? 32'd0 : word;
            if (le)
                return base | ({24'd0, b} << {k, 3'b000});
            else
                return {base[23:0], b};
        end
    endfunction

endpackage

// ===== rtl/eop_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_in_if
// Byte stream channel: one file byte per request, with an end-of-file flag.
// ----------------------------------------------------------------------------
interface eop_in_if;
    import eop_pkg::*;

    logic  valid;
    logic  ready;
    data_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/eop_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_out_if
// Result channel: orientation code and parse status, one request per file.
// ----------------------------------------------------------------------------
interface eop_out_if;
    import eop_pkg::*;

    logic    valid;
    logic    ready;
    code_t   orientation_code;
    status_t status;

    modport source (output valid, output orientation_code, output status, input ready);
    modport sink   (input valid, input orientation_code, input status, output ready);
endinterface

// ===== rtl/exif_orientation_parser.sv =====
`timescale 1ns / 1ps
// Result: a result appears on the result channel in the cycle after the byte that decides it.
// Throughput: one byte per cycle; the parse state and the result register update
// together at each accepted byte, and a byte is taken while the result slot is
// empty or being drained.
// Reset: rst_n clears the parser to the header check at position zero, result empty.
// ----------------------------------------------------------------------------
// exif_orientation_parser
// Streams a file's bytes, checks the APP1 Exif and TIFF headers, walks IFD0
// and reports the mapped Orientation tag, or why it was not found.
// ----------------------------------------------------------------------------
module exif_orientation_parser (
    input  logic      clk,
    input  logic      rst_n,
    eop_in_if.sink    bytes,
    eop_out_if.source result
);
    import eop_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                le_reg, le_next;
    logic [POS_BITS-1:0] dir_reg, dir_next;
    logic [15:0]         total_reg, total_next;
    logic [15:0]         num_reg, num_next;
    logic [3:0]          idx_reg, idx_next;
    logic [31:0]         word_reg, word_next;
    logic                match_reg, match_next;

    logic                out_valid_reg;
    code_t               out_code_reg;
    status_t             out_status_reg;

    logic                accept;
    logic                skip_hit;
    phase_t              cur_phase;
    logic [3:0]          cur_idx;
    logic [31:0]         gw;
    logic [1:0]          k;
    logic [32:0]         start;
    logic [15:0]         num_inc;
    logic                tiff_ok;
    logic                res_hit;
    code_t               res_code;
    status_t             res_status;
    data_t               b;

    assign bytes.ready = !out_valid_reg || result.ready;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data_byte;

    assign result.valid            = out_valid_reg;
    assign result.orientation_code = out_code_reg;
    assign result.status           = out_status_reg;

    // directory reached: count bytes start on this very byte
    assign skip_hit  = (phase_reg == PH_SKIP) && (pos_reg == dir_reg);
    assign cur_phase = skip_hit ? PH_COUNT : phase_reg;
    assign cur_idx   = skip_hit ? 4'd0 : idx_reg;
    assign num_inc   = num_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        le_next    = le_reg;
        dir_next   = dir_reg;
        total_next = total_reg;
        num_next   = num_reg;
        idx_next   = cur_idx;
        word_next  = word_reg;
        match_next = match_reg;
        res_hit    = 1'b0;
        res_code   = 3'd0;
        res_status = ST_FOUND;
        gw         = 32'd0;
        k          = 2'd0;
        start      = 33'd0;
        tiff_ok    = 1'b1;

        if (skip_hit)
        begin
            phase_next = PH_COUNT;
        end

        unique case (cur_phase)
            PH_HEADER:
            begin
                if (pos_reg < POS_BITS'(4))
                begin
                    if (b != marker_byte(pos_reg[1:0]))
                    begin
                        res_hit = 1'b1; res_status = ST_BAD_MARKER;
                    end
                end
                else if (pos_reg < POS_BITS'(6))
                begin
                    // segment size, ignore
                end
                else if (pos_reg < POS_BITS'(12))
                begin
                    if (b != exif_byte(pos_reg[2:0] - 3'd6))
                    begin
                        res_hit = 1'b1; res_status = ST_BAD_EXIF;
                    end
                end
                else if (pos_reg < POS_BITS'(16))
                begin
                    case (pos_reg[1:0])
                        2'd0:
                        begin
                            tiff_ok = (b == CH_I) || (b == CH_M);
                            le_next = (b == CH_I);
                        end
                        2'd1:    tiff_ok = (b == (le_reg ? CH_I : CH_M));
                        2'd2:    tiff_ok = (b == (le_reg ? TIFF_MAGIC : 8'h00));
                        default: tiff_ok = (b == (le_reg ? 8'h00 : TIFF_MAGIC));
                    endcase
                    if (!tiff_ok)
                    begin
                        res_hit = 1'b1; res_status = ST_BAD_TIFF;
                    end
                end
                else
                begin
                    gw        = gather(word_reg, b, pos_reg[1:0], le_reg);
                    word_next = gw;
                    if (pos_reg == POS_BITS'(19))
                    begin
                        start = {1'b0, gw} + IFD_BASE;
                        if (start < IFD_MIN || start > {{(33-POS_BITS){1'b0}}, POS_MAX})
                        begin
                            res_hit = 1'b1; res_status = ST_TAG_MISSING;
                        end
                        else
                        begin
                            dir_next   = start[POS_BITS-1:0];
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end

            PH_COUNT:
            begin
                gw        = gather(word_reg, b, {1'b0, cur_idx[0]}, le_reg);
                word_next = gw;
                if (cur_idx == 4'd0)
                begin
                    idx_next = 4'd1;
                end
                else
                begin
                    total_next = gw[15:0];
                    idx_next   = 4'd0;
                    num_next   = 16'd0;
                    match_next = 1'b1;
                    if (gw[15:0] == 16'd0)
                    begin
                        res_hit = 1'b1; res_status = ST_TAG_MISSING;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
            end

            PH_ENTRY:
            begin
                if (cur_idx < 4'd2 || (cur_idx >= 4'd4 && cur_idx < 4'd8))
                    k = cur_idx[1:0];
                else
                    k = {1'b0, cur_idx[0]};
                if (cur_idx < 4'd10)
                begin
                    gw        = gather(word_reg, b, k, le_reg);
                    word_next = gw;
                end
                if (cur_idx == 4'd1 && gw != {16'd0, ORIENT_TAG})
                    match_next = 1'b0;
                if (cur_idx == 4'd3 && gw != {16'd0, TYPE_SHORT})
                    match_next = 1'b0;
                if (cur_idx == 4'd7 && gw != COUNT_ONE)
                    match_next = 1'b0;

                if (cur_idx == 4'd9 && match_reg)
                begin
                    res_hit = 1'b1;
                    if (gw[15:0] >= 16'd1 && gw[15:0] <= 16'd8)
                    begin
                        res_code   = orient_code(gw[2:0] - 3'd1);
                        res_status = ST_FOUND;
                    end
                    else
                    begin
                        res_status = ST_BAD_VALUE;
                    end
                end
                else if (cur_idx >= 4'd11)
                begin
                    idx_next   = 4'd0;
                    match_next = 1'b1;
                    num_next   = num_inc;
                    if (num_inc == total_reg)
                    begin
                        res_hit = 1'b1; res_status = ST_TAG_MISSING;
                    end
                end
                else
                begin
                    idx_next = cur_idx + 4'd1;
                end
            end

            default:
            begin
                // skip or done: hold
            end
        endcase

        if (phase_reg != PH_DONE)
        begin
            if (!res_hit && pos_reg == POS_MAX)
            begin
                res_hit = 1'b1; res_status = ST_TAG_MISSING;
            end
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + POS_BITS'(1);
        end

        if (res_hit)
            phase_next = PH_DONE;

        if (bytes.last_byte)
        begin
            if (!res_hit && phase_reg != PH_DONE)
            begin
                res_hit    = 1'b1;
                res_code   = 3'd0;
                res_status = ST_TAG_MISSING;
                if (phase_reg == PH_HEADER)
                begin
                    if (pos_reg < POS_BITS'(4))
                        res_status = ST_BAD_MARKER;
                    else if (pos_reg < POS_BITS'(12))
                        res_status = ST_BAD_EXIF;
                    else if (pos_reg < POS_BITS'(16))
                        res_status = ST_BAD_TIFF;
                end
            end
            // re-arm for the next file
            phase_next = PH_HEADER;
            pos_next   = '0;
            le_next    = 1'b0;
            dir_next   = '0;
            total_next = 16'd0;
            num_next   = 16'd0;
            idx_next   = 4'd0;
            word_next  = 32'd0;
            match_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            le_reg        <= 1'b0;
            dir_reg       <= '0;
            total_reg     <= 16'd0;
            num_reg       <= 16'd0;
            idx_reg       <= 4'd0;
            word_reg      <= 32'd0;
            match_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                le_reg    <= le_next;
                dir_reg   <= dir_next;
                total_reg <= total_next;
                num_reg   <= num_next;
                idx_reg   <= idx_next;
                word_reg  <= word_next;
                match_reg <= match_next;
            end
            if (accept && res_hit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each new request
    always_ff @(posedge clk)
    begin
        if (accept && res_hit)
        begin
            out_code_reg   <= res_code;
            out_status_reg <= res_status;
        end
    end

endmodule
